// ===== rtl/tlbpt_pkg.sv =====
// Shared types and constants for the TLB page table translator.
// Used by the controller, the datapath and the top level.
package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int FRAME_OUT_W = 8;
    localparam int COUNT_W     = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } tlbpt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic in_ready;
        logic accept;
        logic commit;
    } tlbpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_stall;
    } tlbpt_status_t;

endpackage

// ===== rtl/tlbpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tlbpt_ctrl.sv =====
// Controller state machine: page table clearing pass, request intake and commit.
// Depends on tlbpt_pkg.
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  tlbpt_status_t status,
    output tlbpt_cmd_t    cmd
);

    tlbpt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // The result register must be free before the item commits.
                if (!status.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/tlbpt_datapath.sv =====
// Datapath: TLB registers with parallel compare, page table memory, frame
// allocator, saturating counters and the result register.
// Depends on tlbpt_pkg and tlbpt_ram.
module tlbpt_datapath
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tlbpt_cmd_t             cmd,
    output tlbpt_status_t          status,
    input  logic [ADDR_W-1:0]      logical_address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ADDR_W-1:0]      physical_address,
    output logic [FRAME_OUT_W-1:0] frame_number,
    output logic                   tlb_hit,
    output logic                   page_fault,
    output logic [COUNT_W-1:0]     address_count,
    output logic [COUNT_W-1:0]     miss_count,
    output logic [COUNT_W-1:0]     fault_count
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = PAGE_W;
    localparam int NEXT_W  = $clog2(PAGE_COUNT + 1);
    localparam int TLB_W   = $clog2(TLB_ENTRIES);
    localparam logic [ADDR_W-1:0] PAGE_COUNT_A = ADDR_W'(PAGE_COUNT);
    localparam logic [NEXT_W-1:0] PAGE_COUNT_N = NEXT_W'(PAGE_COUNT);
    localparam logic [PAGE_W-1:0] CLEAR_LAST   = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [TLB_W-1:0]  TLB_LAST     = TLB_W'(TLB_ENTRIES - 1);

    // TLB storage.
    logic [PAGE_W-1:0]  tlb_page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [TLB_W-1:0]   fifo_ptr_reg;

    logic [NEXT_W-1:0]  next_free_reg;
    logic [PAGE_W-1:0]  clear_cnt_reg;
    logic [COUNT_W-1:0] addr_cnt_reg, miss_cnt_reg, fault_cnt_reg;

    // Request held between intake and commit.
    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   hit_reg;
    logic [FRAME_W-1:0]     hit_frame_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [ADDR_W-1:0]      phys_reg;
    logic [FRAME_OUT_W-1:0] frame_out_reg;
    logic                   hit_out_reg, fault_out_reg;

    // Lookup of the incoming request.
    logic [ADDR_W-1:0]  vpage_wide;
    logic [PAGE_W-1:0]  in_page;
    logic               lookup_hit;
    logic [FRAME_W-1:0] lookup_frame;

    // Commit logic.
    logic [FRAME_W:0]   rd_data;
    logic               tbl_valid;
    logic [FRAME_W-1:0] tbl_frame;
    logic [FRAME_W-1:0] new_frame;
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic               ram_we;
    logic [PAGE_W-1:0]  ram_waddr;
    logic [FRAME_W:0]   ram_wdata;
    logic [FRAME_W+OFFSET_BITS-1:0] phys_wide;
    logic [COUNT_W-1:0] addr_cnt_next, miss_cnt_next, fault_cnt_next;

    assign vpage_wide = logical_address >> OFFSET_BITS;
    assign in_page    = PAGE_W'(vpage_wide % PAGE_COUNT_A);

    // Lowest-numbered valid match wins, so scan from the top down.
    always_comb begin
        lookup_hit   = 1'b0;
        lookup_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == in_page)) begin
                lookup_hit   = 1'b1;
                lookup_frame = tlb_frame_reg[i];
            end
        end
    end

    assign tbl_valid = rd_data[FRAME_W];
    assign tbl_frame = rd_data[FRAME_W-1:0];
    assign new_frame = (next_free_reg == PAGE_COUNT_N) ? '0 : FRAME_W'(next_free_reg);
    assign fault     = !hit_reg && !tbl_valid;
    assign frame     = hit_reg ? hit_frame_reg : (tbl_valid ? tbl_frame : new_frame);
    assign phys_wide = {frame, offset_reg};

    // The clearing pass and fault updates share the one write port.
    assign ram_we    = cmd.clear_en || (cmd.commit && fault);
    assign ram_waddr = cmd.clear_en ? clear_cnt_reg : page_reg;
    assign ram_wdata = cmd.clear_en ? '0 : {1'b1, new_frame};

    assign addr_cnt_next  = (addr_cnt_reg == '1) ? addr_cnt_reg : addr_cnt_reg + 1'b1;
    assign miss_cnt_next  = (miss_cnt_reg == '1) ? miss_cnt_reg : miss_cnt_reg + 1'b1;
    assign fault_cnt_next = (fault_cnt_reg == '1) ? fault_cnt_reg : fault_cnt_reg + 1'b1;

    tlbpt_ram #(
        .WIDTH (FRAME_W + 1),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.accept),
        .rd_addr (in_page),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlb_valid_reg <= '0;
            fifo_ptr_reg  <= '0;
            next_free_reg <= '0;
            clear_cnt_reg <= '0;
            addr_cnt_reg  <= '0;
            miss_cnt_reg  <= '0;
            fault_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_en) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                addr_cnt_reg  <= addr_cnt_next;
                out_valid_reg <= 1'b1;
                if (!hit_reg) begin
                    miss_cnt_reg                <= miss_cnt_next;
                    tlb_valid_reg[fifo_ptr_reg] <= 1'b1;
                    fifo_ptr_reg <= (fifo_ptr_reg == TLB_LAST) ? '0 : fifo_ptr_reg + 1'b1;
                end
                if (fault) begin
                    fault_cnt_reg <= fault_cnt_next;
                    if (next_free_reg != PAGE_COUNT_N) begin
                        next_free_reg <= next_free_reg + 1'b1;
                    end
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            page_reg      <= in_page;
            offset_reg    <= logical_address[OFFSET_BITS-1:0];
            hit_reg       <= lookup_hit;
            hit_frame_reg <= lookup_frame;
        end
        if (cmd.commit) begin
            if (!hit_reg) begin
                tlb_page_reg[fifo_ptr_reg]  <= page_reg;
                tlb_frame_reg[fifo_ptr_reg] <= frame;
            end
            phys_reg      <= ADDR_W'(phys_wide);
            frame_out_reg <= FRAME_OUT_W'(frame);
            hit_out_reg   <= hit_reg;
            fault_out_reg <= fault;
        end
    end

    assign status.clear_last = (clear_cnt_reg == CLEAR_LAST);
    assign status.out_stall  = out_valid_reg && !out_ready;

    assign out_valid        = out_valid_reg;
    assign physical_address = phys_reg;
    assign frame_number     = frame_out_reg;
    assign tlb_hit          = hit_out_reg;
    assign page_fault       = fault_out_reg;
    assign address_count    = addr_cnt_reg;
    assign miss_count       = miss_cnt_reg;
    assign fault_count      = fault_cnt_reg;

endmodule

// ===== rtl/tlb_page_table_translator_unit.sv =====
// Translates logical addresses through a FIFO-replaced, fully associative TLB
// backed by a page table memory that hands out frames in order on a page fault.
// After reset the page table is swept clear, one entry a cycle, while s_ready
// stays low. The TLB compare and page table read happen in the cycle a request
// is accepted (ST_IDLE); the page table update, TLB fill and counter update
// happen at its commit in ST_LOOKUP. A new request is taken only after the last
// one commits. The result sits in an output register and may wait there while
// the next request is taken; a request whose result cannot be stored holds its
// commit until m_ready frees it.
// Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_datapath and tlbpt_ram.
module tlb_page_table_translator_unit
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ADDR_W-1:0]      s_logical_address,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ADDR_W-1:0]      m_physical_address,
    output logic [FRAME_OUT_W-1:0] m_frame_number,
    output logic                   m_tlb_hit,
    output logic                   m_page_fault,
    output logic [COUNT_W-1:0]     m_address_count,
    output logic [COUNT_W-1:0]     m_miss_count,
    output logic [COUNT_W-1:0]     m_fault_count
);

    tlbpt_cmd_t    cmd;
    tlbpt_status_t status;

    tlbpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .status   (status),
        .cmd      (cmd)
    );

    tlbpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .logical_address  (s_logical_address),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .physical_address (m_physical_address),
        .frame_number     (m_frame_number),
        .tlb_hit          (m_tlb_hit),
        .page_fault       (m_page_fault),
        .address_count    (m_address_count),
        .miss_count       (m_miss_count),
        .fault_count      (m_fault_count)
    );

    assign s_ready = cmd.in_ready;

    // A new result appears only from a commit.
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    // A commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid && !m_ready))
        else $error("commit while result register is stalled");

    // No request is taken while the page table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !s_ready)
        else $error("request accepted during clearing pass");

    // A fault only follows a TLB miss, so faults never outnumber misses.
    a_fault_is_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!(m_tlb_hit && m_page_fault) && (m_fault_count <= m_miss_count)))
        else $error("fault reported on a TLB hit or fault count exceeds miss count");

endmodule
